@@ rtl/insertion_sorter_defines.svh @@
// Assertion macros for the insertion sorter checker.
// Depends on nothing; the using module supplies i_clk and i_rst_n.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define ISORT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ISORT_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/isort_pkg.sv @@
// Shared constants and types for the insertion sorter.
// Depends on nothing; used by the stream interfaces, the cell and the top level.
package isort_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    // One storage slot of the cell chain.
    typedef struct packed {
        logic                     occ;
        logic signed [DATA_W-1:0] value;
    } t_slot;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

endpackage

@@ rtl/isort_stream_if.sv @@
// Valid/ready channel interfaces for input items and sorted results.
// Depends on isort_pkg for the data width.
interface isort_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [isort_pkg::DATA_W-1:0] value;
    logic                                is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface isort_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [isort_pkg::DATA_W-1:0] sorted_value;
    logic                                end_of_set;
    logic                                overflow;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflow, output ready);
endinterface

@@ rtl/isort_cell.sv @@
// One compare-and-shift cell of the insertion sorter chain.
// Depends on isort_pkg for the slot and command types.
module isort_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  isort_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [isort_pkg::DATA_W-1:0] i_new,
    input  isort_pkg::t_slot                    i_left,
    input  logic                                i_left_gt,
    input  isort_pkg::t_slot                    i_right,
    output isort_pkg::t_slot                    o_slot,
    output logic                                o_gt
);

    logic                                r_occ;
    logic signed [isort_pkg::DATA_W-1:0] r_value;
    isort_pkg::t_slot                    n_slot;

    // Empty cells, and cells holding a strictly greater value, give way.
    assign o_gt = !r_occ || (r_value > i_new);

    always_comb begin
        n_slot.occ   = r_occ;
        n_slot.value = r_value;
        if (i_ctrl.insert && o_gt) begin
            if (i_left_gt) begin
                n_slot = i_left;
            end else begin
                n_slot.occ   = 1'b1;
                n_slot.value = i_new;
            end
        end else if (i_ctrl.drain) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_slot.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_slot.value;
    end

    assign o_slot.occ   = r_occ;
    assign o_slot.value = r_value;

endmodule

@@ rtl/insertion_sorter.sv @@
// Insertion sorter: stable ascending sort of signed 32-bit sets, DEPTH values.
// Fill: one request accepted per cycle; the compare-and-shift chain places it
// in the same cycle, so the next request may follow at once.
// Drain: after the last-marked request, results leave the head cell one per
// cycle while ready is high, the first in the next cycle; no request is taken then.
// Reset (synchronous, active low) empties every cell and clears the drop flag.
module insertion_sorter #(
    parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    isort_in_if.sink           i_in,
    isort_out_if.source        o_out
);

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } t_state;

    t_state                r_state;
    logic                  r_dropped;

    isort_pkg::t_slot      w_slot [DEPTH];
    logic                  w_gt   [DEPTH];
    isort_pkg::t_cell_ctrl w_ctrl;
    logic                  w_full;
    logic                  w_in_acc;
    logic                  w_out_acc;

    // The tail cell holds a value only when every cell does.
    assign w_full    = w_slot[DEPTH-1].occ;
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // Insert only when there is room; drop otherwise. Drain shifts toward the head.
    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.drain  = w_out_acc;

    assign i_in.ready = (r_state == S_FILL);

    // The head cell is the output register; its neighbor tells whether more follow.
    assign o_out.valid        = (r_state == S_DRAIN) && w_slot[0].occ;
    assign o_out.sorted_value = w_slot[0].value;
    assign o_out.end_of_set   = !w_slot[1].occ;
    assign o_out.overflow     = r_dropped;

    // Sequencer: collect a set, then stream it out and start over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_dropped <= 1'b0;
        end else begin
            case (r_state)
                S_FILL: begin
                    if (w_in_acc) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_in.is_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_out_acc && o_out.end_of_set) begin
                        r_state   <= S_FILL;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // Chain of cells: head at index 0 holds the smallest value.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        isort_pkg::t_slot w_left;
        isort_pkg::t_slot w_right;
        logic             w_left_gt;

        if (g == 0) begin : g_head
            // Nothing to the left: the head takes the new value when it gives way.
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_slot[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // Drain empties the tail.
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_slot[g+1];
        end

        isort_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_new     (i_in.value),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_slot    (w_slot[g]),
            .o_gt      (w_gt[g])
        );
    end

endmodule

@@ rtl/isort_checker.sv @@
// Port-level checks for the insertion sorter, bound to the top level.
// Depends on insertion_sorter_defines.svh and the insertion_sorter ports.
`include "insertion_sorter_defines.svh"

module isort_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_is_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_end_of_set,
    input logic i_overflow
);

    `ISORT_CHECK(a_no_overlap, !(i_out_valid && i_in_ready), "result shown while taking requests")
    `ISORT_CHECK(a_last_starts, (i_in_valid && i_in_ready && i_is_last) |=> i_out_valid, "no result after last request")
    `ISORT_CHECK(a_end_reopens, (i_out_valid && i_out_ready && i_end_of_set) |=> i_in_ready, "input not reopened after set end")
    `ISORT_CHECK(a_more_follow, (i_out_valid && i_out_ready && !i_end_of_set) |=> (i_out_valid && $stable(i_overflow)), "set cut short or overflow changed")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_is_last    (i_in.is_last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_end_of_set (o_out.end_of_set),
    .i_overflow   (o_out.overflow)
);

@@ tb/sv/isort_sort_check_pkg.sv @@
// Scoreboard for the insertion sorter: tracks each set as its requests are
// accepted and checks the sorted results. Depends on isort_pkg for DATA_W/DEPTH_DEF.
package isort_sort_check_pkg;
    import isort_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_set;
        logic                     overflow;
    } sorted_result_t;

    class sorted_set_tracker;
        int                       depth = DEPTH_DEF;
        logic signed [DATA_W-1:0] held_values[$];   // current set, ascending
        bit                       set_dropped;
        sorted_result_t           awaited[$];
        int                       failures;

        // Place an accepted request behind any equal values; on the last mark,
        // queue the whole set as expected results and start a new set.
        function void note_request(logic signed [DATA_W-1:0] v, logic last);
            int             pos;
            sorted_result_t r;
            if (held_values.size() >= depth) begin
                set_dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] <= v) pos++;
                held_values.insert(pos, v);
            end
            if (last) begin
                foreach (held_values[k]) begin
                    r.value      = held_values[k];
                    r.end_of_set = (k == held_values.size() - 1);
                    r.overflow   = set_dropped;
                    awaited.insert(awaited.size(), r);
                end
                held_values.delete();
                set_dropped = 1'b0;
            end
        endfunction

        function void check_result(logic signed [DATA_W-1:0] v, logic eos, logic ovf);
            sorted_result_t exp_r;
            if (awaited.size() == 0) begin
                $error("unexpected result: sorted_value %0d end_of_set %b overflow %b",
                       v, eos, ovf);
                failures++;
                return;
            end
            exp_r = awaited.pop_front();
            if (v !== exp_r.value) begin
                $error("sorted_value: expected %0d, actual %0d", exp_r.value, v);
                failures++;
            end
            if (eos !== exp_r.end_of_set) begin
                $error("end_of_set: expected %b, actual %b", exp_r.end_of_set, eos);
                failures++;
            end
            if (ovf !== exp_r.overflow) begin
                $error("overflow: expected %b, actual %b", exp_r.overflow, ovf);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

@@ tb/sv/tb_insertion_sorter.sv @@
// Top-level testbench for insertion_sorter: drives sets of signed values,
// predicts the sorted output with the scoreboard. Depends on isort_pkg,
// the stream interfaces and isort_sort_check_pkg.
module tb_insertion_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    import isort_pkg::*;
    import isort_sort_check_pkg::*;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS = 105;   // minimum requests per idling phase

    logic clk = 1'b0;
    logic rst_n;

    // Idle rates in percent, changed by the stimulus between phases.
    int src_idle_pct  = 8;
    int sink_idle_pct = 53;

    // Bump hold_token to ask the receiver for one long hold-off.
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    sorted_set_tracker sb = new;

    isort_in_if  in_ch ();
    isort_out_if out_ch ();

    insertion_sorter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 clk = ~clk;

    // Sample both channels at the edge; note requests before results so a
    // set closed at this edge is already queued when its results arrive.
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_request(in_ch.value, in_ch.is_last);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.sorted_value, out_ch.end_of_set, out_ch.overflow);
    end

    // Receiver: random stalls, plus a long hold-off on request so the drain
    // backs up and the block stops taking requests.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one request, idling first at the current sender rate; return at
    // the edge where it is accepted. Keep valid high when no idle follows.
    task automatic send_request(input logic signed [DATA_W-1:0] v, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.is_last <= last;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Mix extremes, a narrow band around zero (so equal values are common)
    // and full-range values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Send a set of random values; count may exceed the store's depth.
    task automatic send_set(input int count);
        for (int k = 0; k < count; k++)
            send_request(pick_value(), k == count - 1);
    endtask

    initial begin
        int phase_sent;
        int set_len;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.is_last = 1'b0;
        out_ch.ready  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element sets at both extremes.
        send_request(VAL_MAX, 1'b1);
        send_request(VAL_MIN, 1'b1);
        // Extremes mixed with duplicates around zero.
        send_request(0, 1'b0);
        send_request(-1, 1'b0);
        send_request(1, 1'b0);
        send_request(VAL_MAX, 1'b0);
        send_request(VAL_MIN, 1'b0);
        send_request(VAL_MIN, 1'b0);
        send_request(-1, 1'b0);
        send_request(VAL_MAX, 1'b1);
        // All-equal set.
        send_request(3, 1'b0);
        send_request(3, 1'b0);
        send_request(3, 1'b1);
        // Descending input, then alternating bit patterns.
        send_request(4, 1'b0);
        send_request(3, 1'b0);
        send_request(2, 1'b0);
        send_request(-7, 1'b0);
        send_request(32'sh5555_5555, 1'b0);
        send_request(32'shAAAA_AAAA, 1'b1);

        // Three idling phases. Each opens with a big set: exactly full, full
        // with the last-marked request dropped, then several drops under a
        // long receiver hold-off. Small random sets fill the rest.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 8;  sink_idle_pct = 53; set_len = DEPTH_DEF; end
                1: begin src_idle_pct = 53; sink_idle_pct = 8;  set_len = DEPTH_DEF + 1; end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    set_len       = $urandom_range(DEPTH_DEF + 2, DEPTH_DEF + 6);
                    hold_token++;
                end
            endcase
            send_set(set_len);
            phase_sent = set_len;
            while (phase_sent < PHASE_ITEMS) begin
                set_len = ($urandom_range(4) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
                send_set(set_len);
                phase_sent += set_len;
            end
        end

        // Drop valid, let the monitor see the final request, then drain.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #800_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
